@@ design/tfcsc_pkg.sv @@
// Package for the TCP frame checksum and scan classifier: types, constants and helpers.
package tfcsc_pkg;

    localparam logic [2:0] V_NOT_IPV4   = 3'd0;
    localparam logic [2:0] V_BAD_IP     = 3'd1;
    localparam logic [2:0] V_NOT_TCP    = 3'd2;
    localparam logic [2:0] V_BAD_TCP    = 3'd3;
    localparam logic [2:0] V_NULL       = 3'd4;
    localparam logic [2:0] V_XMAS       = 3'd5;
    localparam logic [2:0] V_CLEAN      = 3'd6;
    localparam logic [2:0] V_MALFORMED  = 3'd7;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ALL_ONES       = 16'hFFFF;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  XMAS_PATTERN   = 8'b00101001;
    localparam logic [16:0] ETH_HDR        = 17'd14;

    // Everything the back end needs to judge one finished frame.
    typedef struct packed {
        logic [16:0] len;
        logic [3:0]  hw;
        logic [15:0] tl;
        logic [15:0] hsum;
        logic [15:0] ssum;
        logic [7:0]  hold;
        logic [15:0] ftype;
        logic [7:0]  proto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [47:0] dmac;
        logic [47:0] smac;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  flags;
    } t_rec;

    // Ones'-complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

@@ design/tfcsc_front.sv @@
// Front end: parses frame bytes, captures header fields and folds the running sums.
module tfcsc_front import tfcsc_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_rec       o_rec
);

    localparam logic [16:0] MAX_L = 17'(MAX_FRAME_BYTES);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_hsum, n_hsum, r_ssum, n_ssum, r_tl, n_tl, r_type, n_type;
    logic [15:0] r_sport, n_sport, r_dport, n_dport;
    logic [7:0]  r_hold, n_hold, r_proto, n_proto, r_flags, n_flags;
    logic [3:0]  r_hw, n_hw;
    logic [31:0] r_sip, n_sip, r_dip, n_dip;
    logic [47:0] r_dmac, n_dmac, r_smac, n_smac;
    logic [16:0] p17, hstart, seg_end, off;
    logic        accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_pos = r_pos;   n_hsum = r_hsum; n_ssum = r_ssum; n_tl = r_tl;
        n_type = r_type; n_sport = r_sport; n_dport = r_dport; n_hold = r_hold;
        n_proto = r_proto; n_flags = r_flags; n_hw = r_hw; n_sip = r_sip;
        n_dip = r_dip; n_dmac = r_dmac; n_smac = r_smac;
        p17     = {1'b0, r_pos};
        hstart  = '0;
        seg_end = '0;
        off     = '0;
        o_push  = 1'b0;
        o_rec   = '0;
        if (accept) begin
            if (p17 < MAX_L) begin
                for (int k = 0; k < 6; k++) begin
                    if (r_pos == 16'(k)) n_dmac[47-8*k -: 8] = i_data_byte;
                    if (r_pos == 16'(k + 6)) n_smac[47-8*k -: 8] = i_data_byte;
                end
                for (int k = 0; k < 4; k++) begin
                    if (r_pos == 16'(26 + k)) n_sip[31-8*k -: 8] = i_data_byte;
                    if (r_pos == 16'(30 + k)) n_dip[31-8*k -: 8] = i_data_byte;
                end
                if (r_pos == 16'd12) n_type[15:8] = i_data_byte;
                if (r_pos == 16'd13) n_type[7:0]  = i_data_byte;
                if (r_pos == 16'd14) n_hw = i_data_byte[3:0];
                if (r_pos == 16'd16) n_tl = {i_data_byte, 8'd0};
                if (r_pos == 16'd17) n_tl = {r_tl[15:8], i_data_byte};
                if (r_pos == 16'd23) n_proto = i_data_byte;
                hstart  = ETH_HDR + {11'd0, n_hw, 2'b00};
                seg_end = ETH_HDR + {1'b0, n_tl};
                if (p17 >= ETH_HDR && p17 < hstart) begin
                    if (!r_pos[0]) n_hold = i_data_byte;
                    else n_hsum = oc_add(r_hsum, {r_hold, i_data_byte});
                end else if (n_hw >= 4'd5 && p17 >= hstart && p17 < seg_end) begin
                    if (!r_pos[0]) n_hold = i_data_byte;
                    else n_ssum = oc_add(r_ssum, {r_hold, i_data_byte});
                end
                if (n_hw >= 4'd5 && p17 >= hstart) begin
                    off = p17 - hstart;
                    if (off == 17'd0) n_sport = {i_data_byte, 8'd0};
                    else if (off == 17'd1) n_sport = {r_sport[15:8], i_data_byte};
                    else if (off == 17'd2) n_dport = {i_data_byte, 8'd0};
                    else if (off == 17'd3) n_dport = {r_dport[15:8], i_data_byte};
                    else if (off == 17'd13) n_flags = i_data_byte;
                end
            end
            if (r_pos != 16'hFFFF) n_pos = r_pos + 16'd1;
            if (i_last) begin
                o_push = 1'b1;
                o_rec  = '{len: p17 + 17'd1, hw: n_hw, tl: n_tl, hsum: n_hsum,
                           ssum: n_ssum, hold: n_hold, ftype: n_type, proto: n_proto,
                           sip: n_sip, dip: n_dip, dmac: n_dmac, smac: n_smac,
                           sport: n_sport, dport: n_dport, flags: n_flags};
                n_pos = '0;   n_hsum = '0; n_ssum = '0; n_tl = '0; n_type = '0;
                n_sport = '0; n_dport = '0; n_hold = '0; n_proto = '0; n_flags = '0;
                n_hw = '0;    n_sip = '0;  n_dip = '0; n_dmac = '0; n_smac = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;   r_hsum <= '0; r_ssum <= '0; r_tl <= '0; r_type <= '0;
            r_sport <= '0; r_dport <= '0; r_hold <= '0; r_proto <= '0; r_flags <= '0;
            r_hw <= '0;    r_sip <= '0;  r_dip <= '0; r_dmac <= '0; r_smac <= '0;
        end else begin
            r_pos <= n_pos;   r_hsum <= n_hsum; r_ssum <= n_ssum; r_tl <= n_tl;
            r_type <= n_type; r_sport <= n_sport; r_dport <= n_dport; r_hold <= n_hold;
            r_proto <= n_proto; r_flags <= n_flags; r_hw <= n_hw; r_sip <= n_sip;
            r_dip <= n_dip;   r_dmac <= n_dmac; r_smac <= n_smac;
        end
    end

endmodule

@@ design/tfcsc_queue.sv @@
// Two-entry queue of finished frame records between the front and back ends.
module tfcsc_queue import tfcsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_rec o_head
);

    t_rec       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

@@ design/tfcsc_back.sv @@
// Back end: checks lengths and checksums, gives the verdict and holds the result register.
module tfcsc_back import tfcsc_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_rec        i_head,
    input  logic        i_ready,
    output logic        o_pop,
    output logic        o_valid,
    output logic [2:0]  o_verdict,
    output logic [47:0] o_dest_mac,
    output logic [47:0] o_source_mac,
    output logic [15:0] o_frame_type,
    output logic [31:0] o_source_ip,
    output logic [31:0] o_dest_ip,
    output logic [7:0]  o_ip_proto,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port
);

    localparam logic [16:0] MAX_L = 17'(MAX_FRAME_BYTES);

    logic        r_valid;
    logic [2:0]  verdict;
    logic [16:0] hdr, ip_end, need;
    logic [15:0] seg_len, pad, s_fold;
    logic [18:0] s_all;
    logic [16:0] s_one;
    logic        port_ok;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;

    always_comb begin
        hdr      = {11'd0, i_head.hw, 2'b00};
        ip_end   = ETH_HDR + hdr;
        seg_len  = i_head.tl - hdr[15:0];
        pad      = seg_len[0] ? {i_head.hold, 8'd0} : 16'd0;
        need     = ETH_HDR + {1'b0, i_head.tl};
        if (ip_end + 17'd14 > need) need = ip_end + 17'd14;
        s_all = {3'd0, i_head.ssum} + {3'd0, pad}
              + {3'd0, i_head.sip[31:16]} + {3'd0, i_head.sip[15:0]}
              + {3'd0, i_head.dip[31:16]} + {3'd0, i_head.dip[15:0]}
              + {11'd0, i_head.proto} + {3'd0, seg_len};
        s_one  = {1'b0, s_all[15:0]} + {14'd0, s_all[18:16]};
        s_fold = s_one[15:0] + {15'd0, s_one[16]};
        if (i_head.len < ETH_HDR) verdict = V_MALFORMED;
        else if (i_head.ftype != ETHERTYPE_IPV4) verdict = V_NOT_IPV4;
        else if (i_head.hw < 4'd5 || i_head.len < ip_end || ip_end > MAX_L
                 || {1'b0, i_head.tl} < hdr) verdict = V_MALFORMED;
        else if (i_head.hsum != ALL_ONES) verdict = V_BAD_IP;
        else if (i_head.proto != PROTO_TCP) verdict = V_NOT_TCP;
        else if (i_head.len < need || need > MAX_L) verdict = V_MALFORMED;
        else if (s_fold != ALL_ONES) verdict = V_BAD_TCP;
        else if (i_head.flags == 8'd0) verdict = V_NULL;
        else if (i_head.flags == XMAS_PATTERN) verdict = V_XMAS;
        else verdict = V_CLEAN;
        port_ok = (verdict == V_BAD_TCP) || (verdict == V_NULL)
               || (verdict == V_XMAS) || (verdict == V_CLEAN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_verdict     <= verdict;
            o_dest_mac    <= i_head.dmac;
            o_source_mac  <= i_head.smac;
            o_frame_type  <= i_head.ftype;
            o_source_ip   <= (verdict == V_NOT_IPV4) ? 32'd0 : i_head.sip;
            o_dest_ip     <= (verdict == V_NOT_IPV4) ? 32'd0 : i_head.dip;
            o_ip_proto    <= (verdict == V_NOT_IPV4) ? 8'd0 : i_head.proto;
            o_source_port <= port_ok ? i_head.sport : 16'd0;
            o_dest_port   <= port_ok ? i_head.dport : 16'd0;
        end
    end

endmodule

@@ design/tcp_frame_checksum_scan_classifier.sv @@
// Top level of the TCP frame checksum and scan classifier.
// The block takes an Ethernet frame one byte per transfer, starting at the destination MAC,
// and delivers one verdict transfer for the byte marked last. It accepts one byte every
// clock while the record queue is not full; the front end folds the IP header and TCP
// segment sums as bytes arrive. The finished frame record enters the two-entry record queue
// at the transfer of the last byte; its verdict is loaded into the back end's output
// register when the output side is free. The back end judges one frame per cycle while the
// output side takes each verdict, so even single-byte frames flow at full rate; input ready
// drops only when the queue is full because the output side is stalled. Bytes at or beyond
// MAX_FRAME_BYTES are ignored and any region that needs them is reported malformed.
module tcp_frame_checksum_scan_classifier import tfcsc_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_verdict,
    output logic [47:0] o_dest_mac,
    output logic [47:0] o_source_mac,
    output logic [15:0] o_frame_type,
    output logic [31:0] o_source_ip,
    output logic [31:0] o_dest_ip,
    output logic [7:0]  o_ip_proto,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port
);

    logic push, pop, full, empty;
    t_rec rec, head;

    // The front end parses bytes and pushes one record per frame.
    tfcsc_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data_byte(i_data_byte),
        .i_last(i_last), .i_full(full), .o_ready(o_ready), .o_push(push), .o_rec(rec)
    );

    // The queue lets the byte side keep running while a verdict waits.
    tfcsc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_rec(rec), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_head(head)
    );

    // The back end turns each record into a verdict in its output register.
    tfcsc_back #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_head(head),
        .i_ready(i_ready), .o_pop(pop), .o_valid(o_valid), .o_verdict(o_verdict),
        .o_dest_mac(o_dest_mac), .o_source_mac(o_source_mac),
        .o_frame_type(o_frame_type), .o_source_ip(o_source_ip), .o_dest_ip(o_dest_ip),
        .o_ip_proto(o_ip_proto), .o_source_port(o_source_port), .o_dest_port(o_dest_port)
    );

endmodule
